@@ rtl/core/rwpc_pkg.sv @@
// ----------------------------------------------------------------------------
// rwpc_pkg
// Shared widths, defaults and register indexes for the window compositor.
// ----------------------------------------------------------------------------
package rwpc_pkg;

  localparam int PIXEL_W      = 16;
  localparam int GRAY_W       = 8;
  localparam int WIN_DIM_W    = 11;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 16;

  localparam int DEF_CORNER_RADIUS  = 16;
  localparam int DEF_MAX_WINDOW_DIM = 1024;

  localparam logic [WIN_DIM_W-1:0] RST_WINDOW_WIDTH  = 11'd240;
  localparam logic [WIN_DIM_W-1:0] RST_WINDOW_HEIGHT = 11'd240;
  localparam logic [PIXEL_W-1:0]   RST_BACKGROUND    = 16'h0000;

  localparam int GRAY_COEF_R = 76;
  localparam int GRAY_COEF_G = 150;
  localparam int GRAY_COEF_B = 29;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_WIDTH     = 8'd0,
    CFG_WINDOW_HEIGHT    = 8'd1,
    CFG_ROUNDING_ENABLE  = 8'd2,
    CFG_BACKGROUND_COLOR = 8'd3
  } cfg_idx_t;

endpackage

@@ rtl/core/rwpc_ifs.sv @@
// ----------------------------------------------------------------------------
// rwpc channel interfaces
// Valid/ready channels for pixels in, composited results out, and config.
// ----------------------------------------------------------------------------
interface rwpc_in_if
  import rwpc_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] camera_pixel;

  modport source (output valid, output camera_pixel, input ready);
  modport sink   (input valid, input camera_pixel, output ready);
endinterface

interface rwpc_out_if
  import rwpc_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] display_pixel;
  logic [GRAY_W-1:0]  gray_level;
  logic               frame_end;

  modport source (output valid, output display_pixel, output gray_level,
                  output frame_end, input ready);
  modport sink   (input valid, input display_pixel, input gray_level,
                  input frame_end, output ready);
endinterface

interface rwpc_cfg_if
  import rwpc_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/rounded_window_pixel_compositor_core.sv @@
// ----------------------------------------------------------------------------
// rounded_window_pixel_compositor_core
// Rounded-corner window mask and RGB565 luma for a raster pixel stream.
// ----------------------------------------------------------------------------
// One pixel beat in, one result beat out, one pixel per clock sustained while
// the output takes results; each result is held in a single output register,
// fed by the corner test, the position counters and the luma sum. Input ready
// follows that register (free, or drained this cycle), so a beat is taken
// as the previous result drains, but not while it waits. Config writes are
// always ready and take effect on the next pixel; they leave the column/row
// counters alone. frame_end marks the last pixel of each window.
module rounded_window_pixel_compositor_core
  import rwpc_pkg::*;
#(
  parameter int CORNER_RADIUS  = DEF_CORNER_RADIUS,
  parameter int MAX_WINDOW_DIM = DEF_MAX_WINDOW_DIM
) (
  input  logic        clk,
  input  logic        rst_n,
  rwpc_in_if.sink     in_ch,
  rwpc_out_if.source  out_ch,
  rwpc_cfg_if.sink    cfg_ch
);

  localparam int PW = $clog2(MAX_WINDOW_DIM);
  localparam int DW = $clog2(MAX_WINDOW_DIM + 1);
  localparam int NW = (DW > WIN_DIM_W) ? DW : WIN_DIM_W;
  localparam int RW = $clog2(CORNER_RADIUS + 1);
  localparam int SW = 2 * RW + 1;
  localparam logic [NW-1:0] MAX_N  = NW'(MAX_WINDOW_DIM);
  localparam logic [DW-1:0] RAD_D  = DW'(CORNER_RADIUS);
  localparam logic [SW-1:0] RAD_SQ = SW'(CORNER_RADIUS * CORNER_RADIUS);

  logic [WIN_DIM_W-1:0] width_r;
  logic [WIN_DIM_W-1:0] height_r;
  logic                 round_en_r;
  logic [PIXEL_W-1:0]   bg_r;

  logic [PW-1:0] col_r, col_nxt;
  logic [PW-1:0] row_r, row_nxt;

  logic               out_valid_r;
  logic [PIXEL_W-1:0] disp_r, disp_nxt;
  logic [GRAY_W-1:0]  gray_r, gray_nxt;
  logic               fend_r, fend_nxt;

  logic          in_fire;
  logic [DW-1:0] last_w, last_h;
  logic [DW-1:0] col_d, row_d;
  logic [DW-1:0] dc, dr;
  logic          wrap_col, wrap_row;
  logic          in_cut;

  function automatic logic [DW-1:0] clamp_last(input logic [WIN_DIM_W-1:0] v);
    logic [NW-1:0] x;
    logic [NW-1:0] c;
    x = NW'(v);
    if (x == '0) begin
      c = NW'(1);
    end else if (x > MAX_N) begin
      c = MAX_N;
    end else begin
      c = x;
    end
    return DW'(c - NW'(1));
  endfunction

  function automatic logic [DW-1:0] edge_dist(input logic [DW-1:0] p,
                                              input logic [DW-1:0] last);
    logic [DW-1:0] pc;
    logic [DW-1:0] far;
    pc  = (p > last) ? last : p;
    far = last - pc;
    return (pc < far) ? pc : far;
  endfunction

  function automatic logic corner_cut(input logic [DW-1:0] a_d,
                                      input logic [DW-1:0] b_d);
    logic [SW-1:0] a;
    logic [SW-1:0] b;
    if (a_d >= RAD_D || b_d >= RAD_D) begin
      return 1'b0;
    end
    a = SW'(RW'(RAD_D - a_d));
    b = SW'(RW'(RAD_D - b_d));
    return (a * a + b * b) > RAD_SQ;
  endfunction

  function automatic logic [GRAY_W-1:0] to_gray(input logic [PIXEL_W-1:0] px);
    logic [15:0] r8;
    logic [15:0] g8;
    logic [15:0] b8;
    logic [15:0] sum;
    r8  = {8'd0, px[15:11], 3'd0};
    g8  = {8'd0, px[10:5], 2'd0};
    b8  = {8'd0, px[4:0], 3'd0};
    sum = r8 * 16'(GRAY_COEF_R) + g8 * 16'(GRAY_COEF_G) + b8 * 16'(GRAY_COEF_B);
    return sum[15:8];
  endfunction

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    last_w   = clamp_last(width_r);
    last_h   = clamp_last(height_r);
    col_d    = DW'(col_r);
    row_d    = DW'(row_r);
    dc       = edge_dist(col_d, last_w);
    dr       = edge_dist(row_d, last_h);
    in_cut   = corner_cut(dc, dr);
    wrap_col = (col_d >= last_w);
    wrap_row = (row_d >= last_h);

    disp_nxt = (round_en_r && in_cut) ? bg_r : in_ch.camera_pixel;
    gray_nxt = to_gray(in_ch.camera_pixel);
    fend_nxt = wrap_col && wrap_row;

    col_nxt = col_r;
    row_nxt = row_r;
    if (wrap_col) begin
      col_nxt = '0;
      row_nxt = wrap_row ? '0 : PW'(row_r + PW'(1));
    end else begin
      col_nxt = PW'(col_r + PW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= RST_WINDOW_WIDTH;
      height_r   <= RST_WINDOW_HEIGHT;
      round_en_r <= 1'b0;
      bg_r       <= RST_BACKGROUND;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        CFG_WINDOW_WIDTH:     width_r    <= cfg_ch.data[WIN_DIM_W-1:0];
        CFG_WINDOW_HEIGHT:    height_r   <= cfg_ch.data[WIN_DIM_W-1:0];
        CFG_ROUNDING_ENABLE:  round_en_r <= cfg_ch.data[0];
        CFG_BACKGROUND_COLOR: bg_r       <= cfg_ch.data[PIXEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        col_r       <= col_nxt;
        row_r       <= row_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      disp_r <= disp_nxt;
      gray_r <= gray_nxt;
      fend_r <= fend_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.display_pixel = disp_r;
  assign out_ch.gray_level    = gray_r;
  assign out_ch.frame_end     = fend_r;

  // frame end always restarts the raster at the origin
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && fend_nxt |=> (col_r == '0) && (row_r == '0))
    else $error("position not cleared after frame end");

  // column advances by one inside a row
  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !wrap_col |=> col_r == PW'($past(col_r) + PW'(1)))
    else $error("column did not advance");

  // counters hold when no pixel is taken
  a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(col_r) && $stable(row_r))
    else $error("position moved without a pixel");

  // with rounding off the camera pixel passes unchanged
  a_passthru: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !round_en_r |=> out_ch.display_pixel == $past(in_ch.camera_pixel))
    else $error("pixel altered with rounding off");

  // an empty output stage never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled with empty output stage");

endmodule

@@ tb/sv/tb_rounded_window_pixel_compositor_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rounded_window_pixel_compositor_core
// Self-checking bench for the rounded window compositor. A scoreboard tracks
// the window position and registers, predicts display pixel, luma and frame
// end for every accepted pixel, and checks each result beat in order. Windows
// are resized between phases so that positions land past the edge, and both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_rounded_window_pixel_compositor_core;
  import rwpc_pkg::*;

  typedef struct packed {
    logic [PIXEL_W-1:0] display_pixel;
    logic [GRAY_W-1:0]  gray_level;
    logic               frame_end;
  } window_result_t;

  class window_scoreboard;
    logic [WIN_DIM_W-1:0] width_reg;
    logic [WIN_DIM_W-1:0] height_reg;
    logic                 round_en;
    logic [PIXEL_W-1:0]   bg_color;
    int unsigned          col_pos;
    int unsigned          row_pos;
    window_result_t       expected_q[$];
    int unsigned          mismatches;

    function new();
      width_reg  = RST_WINDOW_WIDTH;
      height_reg = RST_WINDOW_HEIGHT;
      round_en   = 1'b0;
      bg_color   = RST_BACKGROUND;
      col_pos    = 0;
      row_pos    = 0;
      mismatches = 0;
    endfunction

    static function int unsigned clamp_dim(logic [WIN_DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > DEF_MAX_WINDOW_DIM) return DEF_MAX_WINDOW_DIM;
      return v;
    endfunction

    static function int unsigned edge_distance(int unsigned p, int unsigned n);
      int unsigned last;
      int unsigned far;
      last = n - 1;
      if (p > last) p = last;
      far = last - p;
      return (p < far) ? p : far;
    endfunction

    static function bit in_corner_cut(int unsigned dc, int unsigned dr);
      int unsigned a;
      int unsigned b;
      if (dc >= DEF_CORNER_RADIUS || dr >= DEF_CORNER_RADIUS) return 1'b0;
      a = DEF_CORNER_RADIUS - dc;
      b = DEF_CORNER_RADIUS - dr;
      return (a * a + b * b) > (DEF_CORNER_RADIUS * DEF_CORNER_RADIUS);
    endfunction

    static function logic [GRAY_W-1:0] luma_of(logic [PIXEL_W-1:0] px);
      int unsigned r8;
      int unsigned g8;
      int unsigned b8;
      int unsigned acc;
      r8 = px[15:11];
      g8 = px[10:5];
      b8 = px[4:0];
      acc = GRAY_COEF_R * (r8 << 3) + GRAY_COEF_G * (g8 << 2) + GRAY_COEF_B * (b8 << 3);
      return 8'(acc >> 8);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_WINDOW_WIDTH:     width_reg  = data[WIN_DIM_W-1:0];
        CFG_WINDOW_HEIGHT:    height_reg = data[WIN_DIM_W-1:0];
        CFG_ROUNDING_ENABLE:  round_en   = data[0];
        CFG_BACKGROUND_COLOR: bg_color   = data;
        default: ;
      endcase
    endfunction

    function void note_pixel(logic [PIXEL_W-1:0] px);
      int unsigned    w;
      int unsigned    h;
      window_result_t res;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      res.display_pixel = px;
      if (round_en && in_corner_cut(edge_distance(col_pos, w), edge_distance(row_pos, h)))
        res.display_pixel = bg_color;
      res.gray_level = luma_of(px);
      res.frame_end  = 1'b0;
      if (col_pos >= w - 1) begin
        col_pos = 0;
        if (row_pos >= h - 1) begin
          res.frame_end = 1'b1;
          row_pos = 0;
        end else begin
          row_pos++;
        end
      end else begin
        col_pos++;
      end
      expected_q.push_back(res);
    endfunction

    function void check_result(window_result_t got);
      window_result_t exp_res;
      if (expected_q.size() == 0) begin
        $error("unexpected result beat: display_pixel %h gray_level %h frame_end %b",
               got.display_pixel, got.gray_level, got.frame_end);
        mismatches++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (got.display_pixel !== exp_res.display_pixel) begin
        $error("display_pixel: expected %h, got %h", exp_res.display_pixel, got.display_pixel);
        mismatches++;
      end
      if (got.gray_level !== exp_res.gray_level) begin
        $error("gray_level: expected %h, got %h", exp_res.gray_level, got.gray_level);
        mismatches++;
      end
      if (got.frame_end !== exp_res.frame_end) begin
        $error("frame_end: expected %b, got %b", exp_res.frame_end, got.frame_end);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   in_burst;
  bit   out_burst;

  rwpc_in_if  in_ch();
  rwpc_out_if out_ch();
  rwpc_cfg_if cfg_ch();

  window_scoreboard pix_sb = new();

  rounded_window_pixel_compositor_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) pix_sb.write_reg(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) pix_sb.note_pixel(in_ch.camera_pixel);
      if (out_ch.valid && out_ch.ready)
        pix_sb.check_result({out_ch.display_pixel, out_ch.gray_level, out_ch.frame_end});
    end
  end

  // result sink with random stalls
  initial begin
    int unsigned stall;
    logic        taken;
    forever begin
      stall = out_burst ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do begin
        @(negedge clk);
        taken = out_ch.valid;
        @(posedge clk);
      end while (!taken);
    end
  end

  task automatic send_pixel(input logic [PIXEL_W-1:0] px);
    int unsigned gap;
    logic        taken;
    gap = in_burst ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_ch.valid        <= 1'b0;
      in_ch.camera_pixel <= 16'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.camera_pixel <= px;
    do begin
      @(negedge clk);
      taken = in_ch.ready;
      @(posedge clk);
    end while (!taken);
  endtask

  // leaves valid high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    logic taken;
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do begin
      @(negedge clk);
      taken = cfg_ch.ready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic finish_phase();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pix_sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [WIN_DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return WIN_DIM_W'($urandom_range(1, 3));
      2, 3, 4: return WIN_DIM_W'($urandom_range(4, 40));
      5:       return WIN_DIM_W'($urandom_range(32, 64));
      6:       return WIN_DIM_W'($urandom_range(65, 1023));
      7:       return WIN_DIM_W'(DEF_MAX_WINDOW_DIM);
      default: return WIN_DIM_W'($urandom_range(DEF_MAX_WINDOW_DIM + 1, 2047));
    endcase
  endfunction

  function automatic logic [PIXEL_W-1:0] pick_pixel();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      default: return PIXEL_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic shuffle_window();
    logic [CFG_DATA_W-1:0] junk;
    junk = 16'($urandom);
    if ($urandom_range(0, 3) != 0)
      write_reg(CFG_WINDOW_WIDTH, {junk[15:WIN_DIM_W], pick_dim()});
    if ($urandom_range(0, 3) != 0)
      write_reg(CFG_WINDOW_HEIGHT, {junk[WIN_DIM_W-1:WIN_DIM_W-5], pick_dim()});
    if ($urandom_range(0, 3) != 0)
      write_reg(CFG_ROUNDING_ENABLE, {junk[15:1], 1'($urandom_range(0, 3) != 0)});
    if ($urandom_range(0, 3) != 0)
      write_reg(CFG_BACKGROUND_COLOR, pick_pixel());
    if ($urandom_range(0, 5) == 0)
      write_reg(CFG_IDX_W'($urandom_range(CFG_BACKGROUND_COLOR + 1, 255)), junk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int unsigned n_items;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.camera_pixel <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= CFG_WINDOW_WIDTH;
    cfg_ch.data        <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, color extremes
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    send_pixel(16'hF800);
    send_pixel(16'h07E0);
    send_pixel(16'h001F);
    send_pixel(16'h8410);
    send_pixel(16'h0821);
    send_pixel(16'h7BEF);
    finish_phase();

    // zero dimensions act as one: every pixel ends the frame
    write_reg(CFG_WINDOW_WIDTH, '0);
    write_reg(CFG_WINDOW_HEIGHT, '0);
    write_reg(CFG_ROUNDING_ENABLE, 16'h0001);
    write_reg(CFG_BACKGROUND_COLOR, 16'hFFFF);
    cfg_ch.valid <= 1'b0;
    send_pixel(16'h1234);
    send_pixel(16'hFFFF);
    send_pixel(16'h0000);
    finish_phase();

    // tiny window, opposite cuts meet
    write_reg(CFG_WINDOW_WIDTH, 16'd3);
    write_reg(CFG_WINDOW_HEIGHT, 16'd2);
    write_reg(CFG_BACKGROUND_COLOR, 16'h0000);
    cfg_ch.valid <= 1'b0;
    repeat (6) send_pixel(16'hFFFF);
    finish_phase();

    // oversize dimensions clamp to the maximum
    write_reg(CFG_WINDOW_WIDTH, 16'h07FF);
    write_reg(CFG_WINDOW_HEIGHT, 16'hFFFF);
    write_reg(CFG_BACKGROUND_COLOR, 16'hA55A);
    cfg_ch.valid <= 1'b0;
    repeat (4) send_pixel(pick_pixel());
    finish_phase();

    // shrink under the current column: position past the edge
    write_reg(CFG_WINDOW_WIDTH, 16'd2);
    write_reg(CFG_WINDOW_HEIGHT, 16'd1);
    cfg_ch.valid <= 1'b0;
    repeat (3) send_pixel(pick_pixel());
    finish_phase();

    for (int ph = 0; ph < 12; ph++) begin
      shuffle_window();
      in_burst  = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      n_items   = $urandom_range(36, 56);
      repeat (n_items) send_pixel(pick_pixel());
      finish_phase();
    end

    repeat (8) @(posedge clk);
    if (pix_sb.mismatches == 0 && pix_sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/rwpc_pkg.sv
rtl/core/rwpc_ifs.sv
rtl/core/rounded_window_pixel_compositor_core.sv
tb/sv/tb_rounded_window_pixel_compositor_core.sv
